[design/nees_pkg.sv]
// Shared types and codes for the network epidemic event step block.
// Used by nees_div and network_epidemic_event_step; no dependencies.
`default_nettype none

package nees_pkg;

  localparam int MAX_FARMS = 256;
  localparam int FARM_W    = 8;
  localparam int CNT_W     = 9;
  localparam int RATE_W    = 32;
  localparam int TOT_W     = 50;
  localparam int OTOT_W    = 48;
  localparam int DIVD_W    = 48;
  localparam int QUOT_W    = 16;

  localparam logic [1:0] KIND_EVENT   = 2'd0;
  localparam logic [1:0] KIND_SEED    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [2:0] EV_ADD     = 3'd0;
  localparam logic [2:0] EV_DROP    = 3'd1;
  localparam logic [2:0] EV_TRADE   = 3'd2;
  localparam logic [2:0] EV_RECOVER = 3'd3;
  localparam logic [2:0] EV_SEED    = 3'd4;
  localparam logic [2:0] EV_RESTART = 3'd5;
  localparam logic [2:0] EV_NONE    = 3'd6;

  localparam logic [2:0] REG_ADD     = 3'd0;
  localparam logic [2:0] REG_DROP    = 3'd1;
  localparam logic [2:0] REG_TRADE   = 3'd2;
  localparam logic [2:0] REG_RECOVER = 3'd3;
  localparam logic [2:0] REG_PROB    = 3'd4;
  localparam logic [2:0] REG_FARMS   = 3'd5;

  // per-farm record
  typedef struct packed {
    logic [CNT_W-1:0] pcnt;
    logic [CNT_W-1:0] npcnt;
    logic             inf;
    logic             idx;
    logic             rcv;
    logic [15:0]      icnt;
  } rec_t;

endpackage

`default_nettype wire

[design/network_epidemic_event_step.sv]
// Top level: one direct-method stochastic event on a dynamic farm partner network.
// Depends on nees_pkg and nees_div.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tuser kind; s_tdata draws and seed farm
// m_*      out  m_tvalid/m_tready  m_tuser event type; m_tdata event result
// cfg_*    in   cfg_we             cfg_index, cfg_data
//
// Seed, restart and unknown items skip the event draw. A random event walks the
// farm records (farm record RAM port), scans ordered-list entries and shifts
// entries on an erase (list RAM port). rst restores register defaults and an
// empty network at once. s_tready is low while an item is in work; a held result
// stalls the block only once the next one is ready to go out.
`default_nettype none

module network_epidemic_event_step (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [1:0]   s_tuser,   // kind
  input  wire logic [71:0]  s_tdata,   // event_draw, infect_draw, seed_farm
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [2:0]        m_tuser,   // event_type
  output logic [111:0]      m_tdata,   // farm, partner, new_infection, index_recovered,
                                       // index_infections, partnerships, infected_now,
                                       // rate total, zero pad
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import nees_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_SEED  = 5'd2;
  localparam logic [4:0] S_TOT   = 5'd3;
  localparam logic [4:0] S_SC0   = 5'd4;
  localparam logic [4:0] S_SC1   = 5'd5;
  localparam logic [4:0] S_SC2   = 5'd6;
  localparam logic [4:0] S_CAT   = 5'd7;
  localparam logic [4:0] S_DIV   = 5'd8;
  localparam logic [4:0] S_WALK  = 5'd9;
  localparam logic [4:0] S_ASCAN = 5'd10;
  localparam logic [4:0] S_SHIFT = 5'd11;
  localparam logic [4:0] S_AFIN  = 5'd12;
  localparam logic [4:0] S_DRD   = 5'd13;
  localparam logic [4:0] S_DGET  = 5'd14;
  localparam logic [4:0] S_DAPP  = 5'd15;
  localparam logic [4:0] S_DFIN  = 5'd16;
  localparam logic [4:0] S_TRD   = 5'd17;
  localparam logic [4:0] S_TGET  = 5'd18;
  localparam logic [4:0] S_TCHK  = 5'd19;
  localparam logic [4:0] S_TUPD  = 5'd20;
  localparam logic [4:0] S_RFIN  = 5'd21;
  localparam logic [4:0] S_DONE  = 5'd22;

  localparam logic [1:0] CAT_ADD   = 2'd0;
  localparam logic [1:0] CAT_DROP  = 2'd1;
  localparam logic [1:0] CAT_TRADE = 2'd2;
  localparam logic [1:0] CAT_REC   = 2'd3;

  localparam int LA_W = 2 * FARM_W;

  // config
  logic [RATE_W-1:0] link_rate, drop_rate, sale_rate, recovery_rate, infect_prob;
  logic [CNT_W-1:0]  n;

  // network totals
  logic [15:0]       sum_np, pt;
  logic [CNT_W-1:0]  it;
  logic [MAX_FARMS-1:0] rec_ok, row_ok;

  // item and sequencer
  logic [4:0]        st;
  logic [1:0]        kind_r;
  logic [31:0]       draw_r, idraw_r;
  logic [FARM_W-1:0] seed_r;
  logic              pre;
  logic [2:0]        tstep;
  logic [TOT_W-1:0]  acc, lim_a, lim_d, lim_t, total, hi_part, x;
  logic [63:0]       prod;
  logic [1:0]        cat;
  logic [QUOT_W-1:0] q, kk;
  logic [CNT_W-1:0]  wi, sp, send;
  logic              wv, pv, lsel, bump;
  logic [FARM_W-1:0] fi, pd, jj, partner;
  rec_t              cur, prec;

  // result
  logic [2:0]        ev;
  logic [FARM_W-1:0] farm_o;
  logic              newinf, irec;
  logic [15:0]       icnt_o;

  // memories
  rec_t              rec_mem [MAX_FARMS];
  rec_t              rec_q, rec_wdata, rec_view;
  logic [FARM_W-1:0] rec_raddr, rec_waddr, rec_qa;
  logic              rec_we;
  logic [7:0]        pl_mem [2**LA_W];
  logic [7:0]        np_mem [2**LA_W];
  logic [7:0]        pl_q, np_q, lst_wdata;
  logic [LA_W-1:0]   lst_raddr, lst_waddr;
  logic [FARM_W-1:0] lst_qa;
  logic              pl_we, np_we;

  // shared units
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mul_p;
  logic [TOT_W-1:0]  acc_sum;
  logic              div_start, div_busy;
  logic [DIVD_W-1:0] div_dividend;
  logic [RATE_W-1:0] div_divisor;
  logic [QUOT_W-1:0] div_q;

  logic [CNT_W-1:0]  walk_cnt, shift_pos, cfg_farms, fill_n;
  logic [17:0]       fill_prod;
  logic [FARM_W-1:0] scan_val, shift_val;
  logic              do_restart, cfg_farm_wr, infect;
  logic [OTOT_W-1:0] total_sat;

  assign s_tready = (st == S_IDLE);
  assign mul_p    = mul_a * mul_b;
  assign acc_sum  = acc + prod[TOT_W-1:0];

  nees_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_comb begin
    cfg_farms = cfg_data[CNT_W-1:0];
    if (cfg_farms < 9'd2) begin
      cfg_farms = 9'd2;
    end else if (cfg_farms > CNT_W'(MAX_FARMS)) begin
      cfg_farms = CNT_W'(MAX_FARMS);
    end
  end

  assign cfg_farm_wr = cfg_we && (cfg_index == REG_FARMS);
  assign do_restart  = cfg_farm_wr || (st == S_DISP && kind_r == KIND_RESTART);
  assign fill_n      = cfg_farm_wr ? cfg_farms : n;
  assign fill_prod   = fill_n * (fill_n - 9'd1);

  always_comb begin
    if (rec_ok[rec_qa]) begin
      rec_view = rec_q;
    end else begin
      rec_view = '{pcnt: '0, npcnt: n, inf: 1'b0, idx: 1'b0, rcv: 1'b0, icnt: '0};
    end
  end

  always_comb begin
    case (cat) inside
      CAT_ADD:   walk_cnt = (rec_view.npcnt == '0) ? '0 : rec_view.npcnt - 9'd1;
      CAT_DROP,
      CAT_TRADE: walk_cnt = rec_view.pcnt;
      default:   walk_cnt = {{(CNT_W-1){1'b0}}, rec_view.inf};
    endcase
  end

  assign scan_val  = row_ok[fi] ? np_q : lst_qa;
  assign shift_pos = (sp < {1'b0, jj}) ? sp : sp + 9'd1;
  assign shift_val = (lsel && !row_ok[fi]) ? lst_qa : (lsel ? np_q : pl_q);
  assign infect    = rec_view.inf && !cur.inf && (idraw_r < infect_prob);
  assign total_sat = (total[TOT_W-1:OTOT_W] != '0) ? {OTOT_W{1'b1}} : total[OTOT_W-1:0];

  always_comb begin
    rec_raddr    = wi[FARM_W-1:0];
    rec_we       = 1'b0;
    rec_waddr    = fi;
    rec_wdata    = cur;
    lst_raddr    = {fi, sp[FARM_W-1:0]};
    pl_we        = 1'b0;
    np_we        = 1'b0;
    lst_waddr    = {fi, pd};
    lst_wdata    = shift_val;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (st) inside
      S_DISP: rec_raddr = seed_r;
      S_SEED: begin
        rec_waddr     = seed_r;
        rec_wdata     = rec_view;
        rec_wdata.inf = 1'b1;
        rec_wdata.idx = 1'b1;
        rec_we        = !rec_view.inf;
      end
      S_TOT: begin
        case (tstep)
          3'd0: begin mul_a = link_rate;     mul_b = {16'b0, sum_np}; end
          3'd1: begin mul_a = drop_rate;     mul_b = {16'b0, pt}; end
          3'd2: begin mul_a = sale_rate;     mul_b = {16'b0, pt}; end
          3'd3: begin mul_a = recovery_rate; mul_b = {23'b0, it}; end
          default: ;
        endcase
      end
      S_SC0: begin mul_a = draw_r; mul_b = {14'b0, total[TOT_W-1:32]}; end
      S_SC1: begin mul_a = draw_r; mul_b = total[31:0]; end
      S_CAT: begin
        div_start = (x < total);
        if (x < lim_a) begin
          div_dividend = x[DIVD_W-1:0];
          div_divisor  = link_rate;
        end else if (x < lim_d) begin
          div_dividend = DIVD_W'(x - lim_a);
          div_divisor  = drop_rate;
        end else if (x < lim_t) begin
          div_dividend = DIVD_W'(x - lim_d);
          div_divisor  = sale_rate;
        end else begin
          div_dividend = DIVD_W'(x - lim_t);
          div_divisor  = recovery_rate;
        end
      end
      S_SHIFT: begin
        lst_raddr = {fi, shift_pos[FARM_W-1:0]};
        pl_we     = pv && !lsel;
        np_we     = pv && lsel;
      end
      S_AFIN: begin
        pl_we           = 1'b1;
        lst_waddr       = {fi, cur.pcnt[FARM_W-1:0]};
        lst_wdata       = partner;
        rec_we          = 1'b1;
        rec_wdata.pcnt  = cur.pcnt + 9'd1;
        rec_wdata.npcnt = cur.npcnt - 9'd1;
      end
      S_DRD, S_TRD: lst_raddr = {fi, kk[FARM_W-1:0]};
      S_DAPP: begin
        np_we     = 1'b1;
        lst_waddr = {fi, cur.npcnt[FARM_W-1:0]};
        lst_wdata = partner;
      end
      S_DFIN: begin
        rec_we          = 1'b1;
        rec_wdata.pcnt  = cur.pcnt - 9'd1;
        rec_wdata.npcnt = cur.npcnt + 9'd1;
      end
      S_TGET: rec_raddr = pl_q;
      S_TCHK: begin
        rec_we        = infect;
        rec_wdata.inf = 1'b1;
      end
      S_TUPD: begin
        rec_we         = bump;
        rec_waddr      = partner;
        rec_wdata      = prec;
        rec_wdata.icnt = prec.icnt + 16'd1;
      end
      S_RFIN: begin
        rec_we        = 1'b1;
        rec_wdata.inf = 1'b0;
        rec_wdata.rcv = cur.rcv | cur.idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rec_q  <= rec_mem[rec_raddr];
    rec_qa <= rec_raddr;
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
  end

  always_ff @(posedge clk) begin
    pl_q   <= pl_mem[lst_raddr];
    np_q   <= np_mem[lst_raddr];
    lst_qa <= lst_raddr[FARM_W-1:0];
    if (pl_we) begin
      pl_mem[lst_waddr] <= lst_wdata;
    end
    if (np_we) begin
      np_mem[lst_waddr] <= lst_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_rate     <= 32'd170290;
      drop_rate     <= 32'd16777216;
      sale_rate     <= 32'd16777216;
      recovery_rate <= 32'd3355443;
      infect_prob   <= 32'd1717986918;
      n             <= 9'd200;
      sum_np        <= 16'd39800;
      pt            <= '0;
      it            <= '0;
      rec_ok        <= '0;
      row_ok        <= '0;
      st            <= S_IDLE;
      pre           <= 1'b0;
      tstep         <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (st == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (rec_we) begin
        rec_ok[rec_waddr] <= 1'b1;
      end

      unique case (st)
        S_IDLE: begin
          if (s_tvalid) begin
            kind_r  <= s_tuser;
            draw_r  <= s_tdata[31:0];
            idraw_r <= s_tdata[63:32];
            seed_r  <= s_tdata[71:64];
            ev      <= EV_NONE;
            farm_o  <= '0;
            partner <= '0;
            newinf  <= 1'b0;
            irec    <= 1'b0;
            icnt_o  <= '0;
            st      <= S_DISP;
          end
        end
        S_DISP: begin
          unique case (kind_r)
            KIND_SEED: begin
              farm_o <= seed_r;
              st     <= ({1'b0, seed_r} < n) ? S_SEED : S_TOT;
            end
            KIND_RESTART: begin
              ev <= EV_RESTART;
              st <= S_TOT;
            end
            KIND_EVENT: begin
              pre <= 1'b1;
              st  <= S_TOT;
            end
            default: st <= S_TOT;
          endcase
        end
        S_SEED: begin
          if (!rec_view.inf) begin
            it <= it + 9'd1;
            ev <= EV_SEED;
          end
          st <= S_TOT;
        end
        S_TOT: begin
          prod <= mul_p;
          case (tstep)
            3'd0: tstep <= tstep + 3'd1;
            3'd1: begin
              acc   <= prod[TOT_W-1:0];
              lim_a <= prod[TOT_W-1:0];
              tstep <= tstep + 3'd1;
            end
            3'd2: begin acc <= acc_sum; lim_d <= acc_sum; tstep <= tstep + 3'd1; end
            3'd3: begin acc <= acc_sum; lim_t <= acc_sum; tstep <= tstep + 3'd1; end
            default: begin
              total <= acc_sum;
              tstep <= '0;
              pre   <= 1'b0;
              st    <= pre ? S_SC0 : S_DONE;
            end
          endcase
        end
        S_SC0: begin
          prod <= mul_p;
          st   <= S_SC1;
        end
        S_SC1: begin
          hi_part <= prod[TOT_W-1:0];
          prod    <= mul_p;
          st      <= S_SC2;
        end
        S_SC2: begin
          x  <= hi_part + {18'b0, prod[63:32]};
          st <= S_CAT;
        end
        S_CAT: begin
          if (x < lim_a) begin
            cat <= CAT_ADD;
          end else if (x < lim_d) begin
            cat <= CAT_DROP;
          end else if (x < lim_t) begin
            cat <= CAT_TRADE;
          end else begin
            cat <= CAT_REC;
          end
          st <= (x < total) ? S_DIV : S_TOT;
        end
        S_DIV: begin
          if (!div_busy) begin
            q  <= div_q;
            wi <= '0;
            wv <= 1'b0;
            st <= S_WALK;
          end
        end
        S_WALK: begin
          if (wi < n) begin
            wi <= wi + 9'd1;
            wv <= 1'b1;
          end else begin
            wv <= 1'b0;
          end
          if (wv) begin
            if (q < QUOT_W'(walk_cnt)) begin
              fi  <= rec_qa;
              cur <= rec_view;
              kk  <= q;
              sp  <= '0;
              pv  <= 1'b0;
              unique case (cat)
                CAT_ADD:   st <= S_ASCAN;
                CAT_DROP:  st <= S_DRD;
                CAT_TRADE: st <= S_TRD;
                default:   st <= S_RFIN;
              endcase
            end else begin
              q <= q - QUOT_W'(walk_cnt);
              if ({1'b0, rec_qa} == n - 9'd1) begin
                st <= S_TOT;
              end
            end
          end
        end
        S_ASCAN: begin
          if (pv && scan_val != fi && kk == '0) begin
            partner <= scan_val;
            jj      <= lst_qa;
            sp      <= row_ok[fi] ? {1'b0, lst_qa} : '0;
            send    <= cur.npcnt - 9'd1;
            lsel    <= 1'b1;
            pv      <= 1'b0;
            st      <= S_SHIFT;
          end else begin
            if (sp < cur.npcnt) begin
              sp <= sp + 9'd1;
              pv <= 1'b1;
            end else begin
              pv <= 1'b0;
            end
            if (pv) begin
              if (scan_val != fi) begin
                kk <= kk - 16'd1;
              end
              if ({1'b0, lst_qa} == cur.npcnt - 9'd1) begin
                st <= S_TOT;
              end
            end
          end
        end
        S_SHIFT: begin
          pd <= sp[FARM_W-1:0];
          if (sp < send) begin
            sp <= sp + 9'd1;
            pv <= 1'b1;
          end else begin
            pv <= 1'b0;
            if (!pv) begin
              st <= lsel ? S_AFIN : S_DFIN;
            end
          end
        end
        S_AFIN: begin
          row_ok[fi] <= 1'b1;
          pt         <= pt + 16'd1;
          sum_np     <= sum_np - 16'd1;
          farm_o     <= fi;
          ev         <= EV_ADD;
          st         <= S_TOT;
        end
        S_DRD: st <= S_DGET;
        S_DGET: begin
          partner <= pl_q;
          st      <= S_DAPP;
        end
        S_DAPP: begin
          sp   <= {1'b0, kk[FARM_W-1:0]};
          jj   <= kk[FARM_W-1:0];
          send <= cur.pcnt - 9'd1;
          lsel <= 1'b0;
          pv   <= 1'b0;
          st   <= S_SHIFT;
        end
        S_DFIN: begin
          if (pt != '0) begin
            pt <= pt - 16'd1;
          end
          sum_np <= sum_np + 16'd1;
          farm_o <= fi;
          ev     <= EV_DROP;
          st     <= S_TOT;
        end
        S_TRD: st <= S_TGET;
        S_TGET: begin
          partner <= pl_q;
          st      <= S_TCHK;
        end
        S_TCHK: begin
          farm_o <= fi;
          ev     <= EV_TRADE;
          prec   <= rec_view;
          bump   <= infect && rec_view.idx && !rec_view.rcv && (rec_view.icnt != 16'hFFFF);
          if (infect) begin
            newinf <= 1'b1;
            it     <= it + 9'd1;
          end
          st <= S_TUPD;
        end
        S_TUPD: st <= S_TOT;
        S_RFIN: begin
          if (it != '0) begin
            it <= it - 9'd1;
          end
          if (cur.idx && !cur.rcv) begin
            irec   <= 1'b1;
            icnt_o <= cur.icnt;
          end
          farm_o <= fi;
          ev     <= EV_RECOVER;
          st     <= S_TOT;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tuser  <= ev;
            m_tdata  <= {5'b0, total_sat, it, pt, icnt_o, irec, newinf, partner, farm_o};
            st       <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase

      if (cfg_we) begin
        unique case (cfg_index)
          REG_ADD:     link_rate     <= cfg_data;
          REG_DROP:    drop_rate     <= cfg_data;
          REG_TRADE:   sale_rate     <= cfg_data;
          REG_RECOVER: recovery_rate <= cfg_data;
          REG_PROB:    infect_prob   <= cfg_data;
          REG_FARMS:   n             <= cfg_farms;
          default: ;
        endcase
      end

      if (do_restart) begin
        rec_ok <= '0;
        row_ok <= '0;
        pt     <= '0;
        it     <= '0;
        sum_np <= fill_prod[15:0];
      end
    end
  end

endmodule

`default_nettype wire

[design/nees_div.sv]
// Restoring divider, one quotient bit per cycle; quotient known to fit QUOT_W.
// Depends on nees_pkg.
`default_nettype none

module nees_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [nees_pkg::DIVD_W-1:0] dividend,
  input  wire logic [nees_pkg::RATE_W-1:0] divisor,
  output logic                             busy,
  output logic [nees_pkg::QUOT_W-1:0]      quotient
);
  import nees_pkg::*;

  localparam int DV_W = RATE_W + QUOT_W - 1;
  localparam int ST_W = $clog2(QUOT_W);

  logic [DIVD_W-1:0] rem;
  logic [DV_W-1:0]   dv;
  logic [ST_W-1:0]   step;
  logic              fits;

  assign fits = rem >= DIVD_W'(dv);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      rem      <= dividend;
      dv       <= {divisor, {(QUOT_W-1){1'b0}}};
      step     <= ST_W'(QUOT_W - 1);
      quotient <= '0;
      busy     <= 1'b1;
    end else if (busy) begin
      if (fits) begin
        rem            <= rem - DIVD_W'(dv);
        quotient[step] <= 1'b1;
      end
      dv <= dv >> 1;
      if (step == '0) begin
        busy <= 1'b0;
      end else begin
        step <= step - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[tb/network_epidemic_event_step_tb.sv]
// Self-checking testbench for network_epidemic_event_step: directed and random
// stream transactions, with a scoreboard class that predicts every event result.
// Depends on nees_pkg and the design under design/.
`default_nettype none

module network_epidemic_event_step_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nees_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;

  typedef struct {
    logic [2:0]  ev;
    logic [7:0]  farm;
    logic [7:0]  partner;
    logic        ninf;
    logic        irec;
    logic [15:0] icnt;
    logic [15:0] pships;
    logic [8:0]  infnow;
    logic [47:0] tot;
  } event_result_t;

  class epidemic_scoreboard;
    bit [31:0] add_r, drop_r, trade_r, rec_r, prob;
    int unsigned nfarms;
    bit [7:0] plist [MAX_FARMS][MAX_FARMS];
    bit [7:0] nplist [MAX_FARMS][MAX_FARMS];
    int unsigned pcnt [MAX_FARMS];
    int unsigned npcnt [MAX_FARMS];
    bit inf [MAX_FARMS];
    bit idx [MAX_FARMS];
    bit rcv [MAX_FARMS];
    bit [15:0] icnt [MAX_FARMS];
    int unsigned ptotal, itotal;
    event_result_t pending_q [$];
    int errors;
    int events_seen;

    function new();
      errors = 0;
      events_seen = 0;
      add_r = 170290; drop_r = 16777216; trade_r = 16777216;
      rec_r = 3355443; prob = 1717986918; nfarms = 200;
      clear_network();
    endfunction

    function void clear_network();
      for (int i = 0; i < MAX_FARMS; i++) begin
        pcnt[i] = 0;
        for (int j = 0; j < MAX_FARMS; j++) begin
          plist[i][j] = 0;
          if (j < nfarms) nplist[i][j] = j;
        end
        npcnt[i] = nfarms;
        inf[i] = 0; idx[i] = 0; rcv[i] = 0; icnt[i] = 0;
      end
      ptotal = 0;
      itotal = 0;
    endfunction

    function void set_reg(logic [2:0] index, logic [31:0] value);
      bit [8:0] v;
      case (index)
        REG_ADD:     add_r = value;
        REG_DROP:    drop_r = value;
        REG_TRADE:   trade_r = value;
        REG_RECOVER: rec_r = value;
        REG_PROB:    prob = value;
        REG_FARMS: begin
          v = value[8:0];
          nfarms = (v < 2) ? 2 : (v > MAX_FARMS) ? MAX_FARMS : v;
          clear_network();
        end
        default: ;
      endcase
    endfunction

    function longint unsigned add_weight(int unsigned f);
      return npcnt[f] > 0 ? longint'(add_r) * (npcnt[f] - 1) : 0;
    endfunction

    function longint unsigned sum_add();
      longint unsigned s;
      s = 0;
      for (int i = 0; i < nfarms; i++) s += add_weight(i);
      return s;
    endfunction

    function longint unsigned rate_sum();
      return sum_add() + longint'(drop_r) * ptotal + longint'(trade_r) * ptotal +
             longint'(rec_r) * itotal;
    endfunction

    function void note(logic [1:0] kind, logic [31:0] draw, logic [31:0] idraw,
                       logic [7:0] seed);
      event_result_t r;
      longint unsigned a, d, t, total, x, w, k;
      int unsigned j, p;
      r = '{ev: EV_NONE, farm: 0, partner: 0, ninf: 0, irec: 0, icnt: 0,
            pships: 0, infnow: 0, tot: 0};
      if (kind == KIND_SEED) begin
        r.farm = seed;
        if (seed < nfarms && !inf[seed]) begin
          inf[seed] = 1; idx[seed] = 1; itotal++;
          r.ev = EV_SEED;
        end
      end else if (kind == KIND_RESTART) begin
        clear_network();
        r.ev = EV_RESTART;
      end else if (kind == KIND_EVENT) begin
        a = sum_add();
        d = longint'(drop_r) * ptotal;
        t = longint'(trade_r) * ptotal;
        total = a + d + t + longint'(rec_r) * itotal;
        x = longint'(draw) * (total >> 32) + ((longint'(draw) * (total & 64'hFFFFFFFF)) >> 32);
        if (x < a) begin
          for (int i = 0; i < nfarms; i++) begin
            w = add_weight(i);
            if (x < w) begin
              k = x / add_r;
              for (j = 0; j < npcnt[i]; j++) begin
                if (nplist[i][j] == i) continue;
                if (k == 0) break;
                k--;
              end
              if (j < npcnt[i] && pcnt[i] < MAX_FARMS) begin
                r.partner = nplist[i][j];
                plist[i][pcnt[i]] = nplist[i][j];
                pcnt[i]++;
                for (int m = j; m + 1 < npcnt[i]; m++) nplist[i][m] = nplist[i][m+1];
                npcnt[i]--;
                ptotal++;
                r.farm = i;
                r.ev = EV_ADD;
              end
              break;
            end
            x -= w;
          end
        end else if (x < a + d) begin
          x -= a;
          for (int i = 0; i < nfarms; i++) begin
            w = longint'(drop_r) * pcnt[i];
            if (x < w) begin
              j = 32'(x / drop_r);
              if (j < pcnt[i] && npcnt[i] < MAX_FARMS) begin
                r.partner = plist[i][j];
                nplist[i][npcnt[i]] = plist[i][j];
                npcnt[i]++;
                for (int m = j; m + 1 < pcnt[i]; m++) plist[i][m] = plist[i][m+1];
                pcnt[i]--;
                if (ptotal > 0) ptotal--;
                r.farm = i;
                r.ev = EV_DROP;
              end
              break;
            end
            x -= w;
          end
        end else if (x < a + d + t) begin
          x -= a + d;
          for (int i = 0; i < nfarms; i++) begin
            w = longint'(trade_r) * pcnt[i];
            if (x < w) begin
              j = 32'(x / trade_r);
              if (j < pcnt[i]) begin
                p = plist[i][j];
                r.partner = p;
                r.farm = i;
                r.ev = EV_TRADE;
                if (inf[p] && !inf[i] && idraw < prob) begin
                  inf[i] = 1; itotal++;
                  r.ninf = 1;
                  if (idx[p] && !rcv[p] && icnt[p] != 16'hFFFF) icnt[p]++;
                end
              end
              break;
            end
            x -= w;
          end
        end else if (x < total) begin
          x -= a + d + t;
          for (int i = 0; i < nfarms; i++) begin
            if (!inf[i]) continue;
            if (x < rec_r) begin
              inf[i] = 0;
              if (itotal > 0) itotal--;
              r.farm = i;
              r.ev = EV_RECOVER;
              if (idx[i] && !rcv[i]) begin
                rcv[i] = 1; r.irec = 1; r.icnt = icnt[i];
              end
              break;
            end
            x -= rec_r;
          end
        end
      end
      total = rate_sum();
      r.tot = (total > 48'hFFFFFFFFFFFF) ? 48'hFFFFFFFFFFFF : total[47:0];
      r.pships = ptotal[15:0];
      r.infnow = itotal[8:0];
      if (r.ev <= EV_RECOVER) events_seen++;
      pending_q.insert(pending_q.size(), r);
    endfunction

    task report(string what, logic [127:0] got, logic [127:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check(logic [2:0] ev, logic [111:0] d);
      event_result_t e;
      if (pending_q.size() == 0) begin
        report("unexpected transaction", d, 0);
        return;
      end
      e = pending_q.pop_front();
      if (ev !== e.ev) report("event_type", ev, e.ev);
      if (d[7:0] !== e.farm) report("farm", d[7:0], e.farm);
      if (d[15:8] !== e.partner) report("partner", d[15:8], e.partner);
      if (d[16] !== e.ninf) report("new_infection", d[16], e.ninf);
      if (d[17] !== e.irec) report("index_recovered", d[17], e.irec);
      if (d[33:18] !== e.icnt) report("index_infections", d[33:18], e.icnt);
      if (d[49:34] !== e.pships) report("partnerships", d[49:34], e.pships);
      if (d[58:50] !== e.infnow) report("infected_now", d[58:50], e.infnow);
      if (d[106:59] !== e.tot) report("rate total", d[106:59], e.tot);
    endtask
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready, cfg_we;
  logic [1:0] s_tuser;
  logic [71:0] s_tdata;
  logic [2:0] m_tuser, cfg_index;
  logic [111:0] m_tdata;
  logic [31:0] cfg_data;
  int idle_mode;
  int cycles;
  int items_sent;
  epidemic_scoreboard sb;

  network_epidemic_event_step uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // result side
  initial begin
    m_tready = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check(m_tuser, m_tdata);
      @(negedge clk);
      m_tready = (idle_mode == 0) ? ($urandom_range(99) >= 70) :
                 (idle_mode == 1) ? ($urandom_range(99) >= 35) : 1'b1;
    end
  end

  task automatic send_item(logic [1:0] kind, logic [31:0] draw, logic [31:0] idraw,
                           logic [7:0] seed);
    int gap;
    gap = (idle_mode == 0) ? 35 : (idle_mode == 1) ? 70 : 0;
    while ($urandom_range(99) < gap) begin
      s_tvalid = 0;
      @(negedge clk);
    end
    s_tvalid = 1;
    s_tuser = kind;
    s_tdata = {seed, idraw, draw};
    do @(posedge clk); while (!s_tready);
    sb.note(kind, draw, idraw, seed);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid = 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] index, logic [31:0] value);
    wait_idle();
    cfg_we = 1;
    cfg_index = index;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 0;
    sb.set_reg(index, value);
  endtask

  task automatic random_item(int unsigned n);
    int r;
    logic [31:0] idraw;
    r = $urandom_range(99);
    idraw = $urandom_range(1) ? $urandom : $urandom_range(32'h7FFFFFFF);
    if (r < 72) send_item(KIND_EVENT, $urandom, idraw, $urandom);
    else if (r < 86)
      send_item(KIND_SEED, $urandom, $urandom,
                ($urandom_range(99) < 80) ? $urandom_range(n - 1) : $urandom_range(255));
    else if (r < 90) send_item(KIND_RESTART, $urandom, $urandom, $urandom);
    else if (r < 93) send_item(2'd3, $urandom, $urandom, $urandom);
    else send_item(KIND_EVENT, $urandom_range(1) ? 32'h0 : 32'hFFFFFFFF, idraw, $urandom);
  endtask

  initial begin
    logic [31:0] farms_val [6];
    sb = new();
    cycles = 0;
    items_sent = 0;
    idle_mode = 0;
    rst = 1;
    s_tvalid = 0; s_tuser = 0; s_tdata = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    repeat (6) @(negedge clk);
    rst = 0;

    // directed: draw extremes, seed corner cases, unknown kind, restart, zero rate
    send_item(KIND_EVENT, 32'h0, 32'h0, 8'h0);
    send_item(KIND_EVENT, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF);
    send_item(KIND_SEED, 32'h0, 32'h0, 8'd0);
    send_item(KIND_SEED, 32'h0, 32'h0, 8'd0);
    send_item(KIND_SEED, 32'h0, 32'h0, 8'd255);
    send_item(KIND_SEED, 32'h0, 32'h0, 8'd199);
    send_item(2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF);
    for (int i = 0; i < 8; i++) send_item(KIND_EVENT, $urandom, 32'h0, $urandom);
    send_item(KIND_EVENT, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'h0);
    send_item(KIND_RESTART, 32'h0, 32'h0, 8'hAA);
    write_reg(REG_ADD, 32'h0);
    send_item(KIND_EVENT, 32'h12345678, 32'h0, 8'h0);
    send_item(KIND_EVENT, 32'hFFFFFFFF, 32'h0, 8'h0);
    write_reg(REG_ADD, 32'd170290);

    farms_val = '{32'd2, 32'd8, 32'h1FF, 32'd16, 32'h200, 32'd6};
    for (int ph = 0; ph < 6; ph++) begin
      idle_mode = ph / 2;
      case (ph)
        2: begin
          write_reg(REG_ADD, 32'hFFFFFFFF); write_reg(REG_DROP, 32'hFFFFFFFF);
          write_reg(REG_TRADE, 32'hFFFFFFFF); write_reg(REG_RECOVER, 32'hFFFFFFFF);
          write_reg(REG_PROB, 32'hFFFFFFFF);
        end
        3: begin
          write_reg(REG_ADD, 32'h0); write_reg(REG_DROP, 32'h1);
          write_reg(REG_TRADE, 32'h1); write_reg(REG_RECOVER, 32'h0);
          write_reg(REG_PROB, 32'h0);
        end
        default: begin
          write_reg(REG_ADD, $urandom_range(32'h0400_0000, 32'h0001_0000));
          write_reg(REG_DROP, $urandom_range(32'h0400_0000, 32'h0001_0000));
          write_reg(REG_TRADE, $urandom_range(32'h0800_0000, 32'h0001_0000));
          write_reg(REG_RECOVER, $urandom_range(32'h0400_0000, 32'h0001_0000));
          write_reg(REG_PROB, $urandom);
        end
      endcase
      write_reg(REG_FARMS, farms_val[ph]);
      for (int i = 0; i < 165; i++) random_item(sb.nfarms);
    end

    wait_idle();
    $display("covered %0d items over six register settings and three idle patterns,",
             items_sent);
    $display("%0d network events predicted, %0d mismatches", sb.events_seen, sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
